// ===== hdl/plt_pkg.sv =====
// Package with the types, constants and codes shared by the positional list table.
`timescale 1ns / 1ps

package plt_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2,
        OP_LOCATE = 2'd3
    } req_op_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_INSERT,
        CELL_DELETE
    } cell_mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] position;
        logic [7:0] value;
    } req_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] elem_out;
        logic [7:0] found_pos;
        logic [7:0] list_len;
    } rsp_t;

    typedef struct packed {
        cell_mode_t       mode;
        logic [IDX_W-1:0] pos_idx;
        logic [7:0]       value;
    } cell_cmd_t;

endpackage

// ===== hdl/plt_cell.sv =====
// One storage cell of the element chain, shifting or rotating with its neighbours.
`timescale 1ns / 1ps

module plt_cell (
    input  logic                    clk,
    input  plt_pkg::cell_cmd_t      cmd,
    input  logic [plt_pkg::IDX_W-1:0] index,
    input  logic [7:0]              left,
    input  logic [7:0]              right,
    output logic [7:0]              data
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.mode)
            plt_pkg::CELL_HOLD:
            begin
                data_next = data_reg;
            end
            plt_pkg::CELL_ROTATE:
            begin
                data_next = right;
            end
            plt_pkg::CELL_INSERT:
            begin
                if (index > cmd.pos_idx)
                begin
                    data_next = left;
                end
                else if (index == cmd.pos_idx)
                begin
                    data_next = cmd.value;
                end
            end
            plt_pkg::CELL_DELETE:
            begin
                if (index >= cmd.pos_idx)
                begin
                    data_next = right;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== hdl/plt_ctrl.sv =====
// Controller: request decode, element count, scan sequencing and result register.
`timescale 1ns / 1ps

module plt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  plt_pkg::req_t      req,
    input  logic [7:0]         head,
    output logic               busy,
    output plt_pkg::cell_cmd_t cmd,
    output logic               done,
    output plt_pkg::rsp_t      rsp
);

    localparam int IDX_W = plt_pkg::IDX_W;
    localparam int CNT_W = plt_pkg::CNT_W;
    localparam int CMP_W = plt_pkg::CMP_W;

    plt_pkg::ctrl_state_t state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic                 loc_reg, loc_next;
    logic [7:0]           pos_reg, pos_next;
    logic [7:0]           val_reg, val_next;
    logic                 ok_reg, ok_next;
    logic                 hit_reg, hit_next;
    logic [7:0]           elem_reg, elem_next;
    logic [7:0]           fpos_reg, fpos_next;
    logic                 done_reg, done_next;
    plt_pkg::rsp_t        rsp_reg, rsp_next;

    plt_pkg::req_op_t op;
    logic             accept;
    logic             k_last;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] k_ext;
    logic             pos_ok;
    logic             ins_ok;

    assign op      = plt_pkg::req_op_t'(req.req_type);
    assign accept  = start && (state_reg == plt_pkg::ST_IDLE);
    assign k_last  = (k_reg == IDX_W'(plt_pkg::CAPACITY - 1));
    assign pos_ext = CMP_W'(req.position);
    assign cnt_ext = CMP_W'(count_reg);
    assign k_ext   = CMP_W'(k_reg);
    assign pos_ok  = (req.position != 8'd0) && (pos_ext <= cnt_ext);
    assign ins_ok  = (count_reg < CNT_W'(plt_pkg::CAPACITY)) && (req.position != 8'd0)
                     && (pos_ext <= cnt_ext + CMP_W'(1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plt_pkg::ST_IDLE:
            begin
                if (accept && (op == plt_pkg::OP_GET || op == plt_pkg::OP_LOCATE))
                begin
                    state_next = plt_pkg::ST_SCAN;
                end
            end
            plt_pkg::ST_SCAN:
            begin
                if (k_last)
                begin
                    state_next = plt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = plt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy        = 1'b0;
        cmd.mode    = plt_pkg::CELL_HOLD;
        cmd.pos_idx = IDX_W'(req.position - 8'd1);
        cmd.value   = req.value;
        unique case (state_reg)
            plt_pkg::ST_IDLE:
            begin
                if (accept && op == plt_pkg::OP_INSERT && ins_ok)
                begin
                    cmd.mode = plt_pkg::CELL_INSERT;
                end
                else if (accept && op == plt_pkg::OP_DELETE && pos_ok)
                begin
                    cmd.mode = plt_pkg::CELL_DELETE;
                end
            end
            plt_pkg::ST_SCAN:
            begin
                busy     = 1'b1;
                cmd.mode = plt_pkg::CELL_ROTATE;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        k_next     = k_reg;
        loc_next   = loc_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        ok_next    = ok_reg;
        hit_next   = hit_reg;
        elem_next  = elem_reg;
        fpos_next  = fpos_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        if (accept)
        begin
            unique case (op)
                plt_pkg::OP_INSERT:
                begin
                    if (ins_ok)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    done_next = 1'b1;
                    rsp_next  = '{ok: ins_ok, elem_out: 8'd0, found_pos: 8'd0,
                                  list_len: 8'(count_next)};
                end
                plt_pkg::OP_DELETE:
                begin
                    if (pos_ok)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    done_next = 1'b1;
                    rsp_next  = '{ok: pos_ok, elem_out: 8'd0, found_pos: 8'd0,
                                  list_len: 8'(count_next)};
                end
                plt_pkg::OP_GET, plt_pkg::OP_LOCATE:
                begin
                    loc_next  = (op == plt_pkg::OP_LOCATE);
                    pos_next  = req.position;
                    val_next  = req.value;
                    ok_next   = (op == plt_pkg::OP_LOCATE) ? 1'b1 : pos_ok;
                    hit_next  = 1'b0;
                    elem_next = 8'd0;
                    fpos_next = 8'd0;
                    k_next    = '0;
                end
                default:
                begin
                    done_next = 1'b0;
                end
            endcase
        end
        else if (state_reg == plt_pkg::ST_SCAN)
        begin
            k_next = k_reg + IDX_W'(1);
            if (!loc_reg && ok_reg && (k_ext == CMP_W'(pos_reg) - CMP_W'(1)))
            begin
                elem_next = head;
            end
            if (loc_reg && !hit_reg && (k_ext < cnt_ext) && (head == val_reg))
            begin
                hit_next  = 1'b1;
                fpos_next = 8'(k_ext + CMP_W'(1));
            end
            if (k_last)
            begin
                done_next = 1'b1;
                rsp_next  = '{ok: ok_reg, elem_out: elem_next, found_pos: fpos_next,
                              list_len: 8'(count_reg)};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plt_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        loc_reg  <= loc_next;
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        ok_reg   <= ok_next;
        hit_reg  <= hit_next;
        elem_reg <= elem_next;
        fpos_reg <= fpos_next;
        rsp_reg  <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== hdl/positional_list_table.sv =====
// Top level of the positional list table: controller and the chain of element cells.
`timescale 1ns / 1ps

// An insert or delete request's result appears on rsp, marked by done, in the cycle after
// it is taken; busy stays low, so such requests may follow every cycle. A get or locate
// request raises busy while the whole cell chain rotates once past its head cell, where the
// position is read or the value compared; the result appears in the same cycle that busy
// falls. Results are shown for exactly one cycle and cannot be stalled, so the receiver
// must take every transfer as it comes. The list is empty after reset.

module positional_list_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  plt_pkg::req_t  req,
    output logic           busy,
    output logic           done,
    output plt_pkg::rsp_t  rsp
);

    localparam int CAP = plt_pkg::CAPACITY;

    plt_pkg::cell_cmd_t cmd;
    logic [7:0]         cell_q [CAP];

    plt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .head  (cell_q[0]),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        logic [7:0] left_d;
        logic [7:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = 8'd0;
        end
        else
        begin : g_inner_left
            assign left_d = cell_q[i-1];
        end

        if (i == CAP - 1)
        begin : g_last
            assign right_d = cell_q[0];
        end
        else
        begin : g_inner_right
            assign right_d = cell_q[i+1];
        end

        plt_cell u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .index (plt_pkg::IDX_W'(i)),
            .left  (left_d),
            .right (right_d),
            .data  (cell_q[i])
        );
    end

endmodule

// ===== hdl/plt_checker.sv =====
// Port-level checks of the positional list table, bound to the top level.
`timescale 1ns / 1ps

module plt_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input plt_pkg::req_t req,
    input logic          busy,
    input logic          done,
    input plt_pkg::rsp_t rsp
);

    logic scan_req;
    logic edit_req;

    assign scan_req = start && !busy && (req.req_type == plt_pkg::OP_GET
                      || req.req_type == plt_pkg::OP_LOCATE);
    assign edit_req = start && !busy && (req.req_type == plt_pkg::OP_INSERT
                      || req.req_type == plt_pkg::OP_DELETE);

    a_scan_busy : assert property (@(posedge clk) disable iff (!rst_n)
        scan_req |=> busy && !done)
    else $error("get or locate transfer did not raise busy");

    a_edit_done : assert property (@(posedge clk) disable iff (!rst_n)
        edit_req |=> done && !busy)
    else $error("insert or delete result missing in the next cycle");

    a_found_ok : assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.found_pos != 8'd0) |-> (rsp.ok && rsp.elem_out == 8'd0))
    else $error("locate hit reported with inconsistent fields");

    a_busy_end : assert property (@(posedge clk) disable iff (!rst_n)
        ($fell(busy)) |-> done)
    else $error("scan ended without a result");

endmodule

bind positional_list_table plt_checker u_plt_checker (.*);

// ===== tb/tb_positional_list_table.sv =====
// Testbench for the positional list table: directed and random requests against a list model.
`timescale 1ns / 1ps

module tb_positional_list_table;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic           clk;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    plt_pkg::req_t  req   = '0;
    logic           busy;
    logic           done;
    plt_pkg::rsp_t  rsp;

    logic [7:0]     shadow_list[$];
    plt_pkg::rsp_t  pending_rsp_q[$];
    int unsigned    mismatch_count = 0;
    int unsigned    cycle_count = 0;
    int unsigned    burst_left = 0;

    positional_list_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic plt_pkg::req_t make_req(plt_pkg::req_op_t op, int unsigned pos,
                                               int unsigned val);
        plt_pkg::req_t r;
        r.req_type = op;
        r.position = pos[7:0];
        r.value    = val[7:0];
        return r;
    endfunction

    // Applies one request to the list model and returns the response it should produce.
    function automatic plt_pkg::rsp_t list_apply(plt_pkg::req_t r);
        plt_pkg::rsp_t o;
        int unsigned   n;
        int unsigned   p;
        o = '0;
        n = shadow_list.size();
        p = r.position;
        case (plt_pkg::req_op_t'(r.req_type))
            plt_pkg::OP_INSERT:
            begin
                if (n < plt_pkg::CAPACITY && p >= 1 && p <= n + 1)
                begin
                    shadow_list.insert(p - 1, r.value);
                    o.ok = 1'b1;
                end
            end
            plt_pkg::OP_DELETE:
            begin
                if (p >= 1 && p <= n)
                begin
                    shadow_list.delete(p - 1);
                    o.ok = 1'b1;
                end
            end
            plt_pkg::OP_GET:
            begin
                if (p >= 1 && p <= n)
                begin
                    o.elem_out = shadow_list[p - 1];
                    o.ok = 1'b1;
                end
            end
            default:
            begin
                o.ok = 1'b1;
                for (int k = 0; k < n; k++)
                begin
                    if (shadow_list[k] == r.value)
                    begin
                        o.found_pos = 8'(k + 1);
                        break;
                    end
                end
            end
        endcase
        o.list_len = 8'(shadow_list.size());
        return o;
    endfunction

    // Random request with mostly valid positions; locates often search for a held value.
    function automatic plt_pkg::req_t random_req(int unsigned ins_pct, int unsigned del_pct,
                                                 int unsigned get_pct);
        plt_pkg::req_t    r;
        int unsigned      n;
        int unsigned      sel;
        plt_pkg::req_op_t op;
        n   = shadow_list.size();
        sel = $urandom_range(99);
        if (sel < ins_pct)
            op = plt_pkg::OP_INSERT;
        else if (sel < ins_pct + del_pct)
            op = plt_pkg::OP_DELETE;
        else if (sel < ins_pct + del_pct + get_pct)
            op = plt_pkg::OP_GET;
        else
            op = plt_pkg::OP_LOCATE;
        r = make_req(op, $urandom_range(255, 0), $urandom_range(255, 0));
        if ($urandom_range(99) < 85)
        begin
            if (op == plt_pkg::OP_INSERT)
                r.position = 8'($urandom_range(n + 1, 1));
            else if (n > 0)
                r.position = 8'($urandom_range(n, 1));
        end
        if (op == plt_pkg::OP_LOCATE && n > 0 && $urandom_range(1))
            r.value = shadow_list[$urandom_range(n - 1, 0)];
        return r;
    endfunction

    task automatic send_req(plt_pkg::req_t item);
        start <= 1'b1;
        req   <= item;
        do
            @(posedge clk);
        while (busy);
        pending_rsp_q.push_back(list_apply(item));
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 20)
                                                  : $urandom_range(8, 1);
        end
        else
        begin
            burst_left--;
        end
    endtask

    function automatic void check_field(string name, int unsigned expected,
                                        int unsigned actual);
        if (expected != actual)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        plt_pkg::rsp_t expected;
        if (rst_n && done)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                $error("response with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                expected = pending_rsp_q.pop_front();
                check_field("ok", expected.ok, rsp.ok);
                check_field("elem_out", expected.elem_out, rsp.elem_out);
                check_field("found_pos", expected.found_pos, rsp.found_pos);
                check_field("list_len", expected.list_len, rsp.list_len);
            end
        end
    end

    task automatic test_empty_list();
        send_req(make_req(plt_pkg::OP_GET, 1, 0));
        send_req(make_req(plt_pkg::OP_DELETE, 1, 0));
        send_req(make_req(plt_pkg::OP_LOCATE, 0, 0));
        send_req(make_req(plt_pkg::OP_INSERT, 0, 8'h11));
        send_req(make_req(plt_pkg::OP_INSERT, 2, 8'h22));
        send_req(make_req(plt_pkg::OP_INSERT, 255, 8'h33));
    endtask

    task automatic test_basic_ops();
        send_req(make_req(plt_pkg::OP_INSERT, 1, 8'h00));
        send_req(make_req(plt_pkg::OP_INSERT, 2, 8'hFF));
        send_req(make_req(plt_pkg::OP_INSERT, 1, 8'hAA));
        send_req(make_req(plt_pkg::OP_INSERT, 2, 8'h55));
        send_req(make_req(plt_pkg::OP_GET, 1, 0));
        send_req(make_req(plt_pkg::OP_GET, 4, 0));
        send_req(make_req(plt_pkg::OP_GET, 5, 0));
        send_req(make_req(plt_pkg::OP_GET, 255, 0));
        send_req(make_req(plt_pkg::OP_GET, 0, 0));
        send_req(make_req(plt_pkg::OP_LOCATE, 0, 8'hFF));
        send_req(make_req(plt_pkg::OP_LOCATE, 0, 8'h12));
        send_req(make_req(plt_pkg::OP_LOCATE, 255, 8'h00));
        send_req(make_req(plt_pkg::OP_DELETE, 2, 0));
        send_req(make_req(plt_pkg::OP_DELETE, 3, 0));
        send_req(make_req(plt_pkg::OP_DELETE, 0, 0));
        send_req(make_req(plt_pkg::OP_DELETE, 255, 0));
        send_req(make_req(plt_pkg::OP_GET, 1, 0));
        send_req(make_req(plt_pkg::OP_LOCATE, 0, 8'h55));
    endtask

    task automatic test_fill_to_capacity();
        while (shadow_list.size() < plt_pkg::CAPACITY)
            send_req(random_req(90, 2, 4));
        repeat (30)
            send_req(random_req(60, 0, 20));
    endtask

    task automatic test_random_mix();
        repeat (1500)
            send_req(random_req(30, 25, 20));
    endtask

    task automatic test_drain();
        while (shadow_list.size() > 0)
            send_req(random_req(5, 85, 5));
        repeat (10)
            send_req(random_req(25, 25, 25));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_basic_ops();
        test_fill_to_capacity();
        test_random_mix();
        test_drain();
        start <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (plt_pkg::CAPACITY + 8) @(posedge clk);
        if (mismatch_count == 0 && pending_rsp_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/plt_pkg.sv
hdl/plt_cell.sv
hdl/plt_ctrl.sv
hdl/positional_list_table.sv
hdl/plt_checker.sv
tb/tb_positional_list_table.sv
